FILE: hw/rtl/cable_clearance_height_controller_macros.svh
// Assertion macros for the cable clearance height controller
`ifndef CABLE_CLEARANCE_HEIGHT_CONTROLLER_MACROS_SVH
`define CABLE_CLEARANCE_HEIGHT_CONTROLLER_MACROS_SVH
`define CCH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: hw/rtl/cchc_pkg.sv
// Shared types and constants for the cable clearance height controller
package cchc_pkg;
   localparam logic [2:0] CSR_POINT_COUNT = 3'd0;
   localparam logic [2:0] CSR_CLEARANCE   = 3'd1;
   localparam logic [2:0] CSR_HALF_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_GAIN        = 3'd3;
   localparam logic [2:0] CSR_DEADBAND    = 3'd4;
   localparam logic [2:0] CSR_MAX_SPEED   = 3'd5;
   localparam logic [2:0] CSR_ALPHA       = 3'd6;
   localparam logic [16:0] Q_ONE = 17'd65536;
   localparam logic [63:0] SEG_MIN = 64'd4;
   localparam logic signed [32:0] SAT_POS = 33'sd2147483647;
   localparam logic signed [32:0] SAT_NEG = -33'sd2147483647;

   // datapath step selector
   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_INIT  = 4'd1;
   localparam logic [3:0] OP_RDA   = 4'd2;
   localparam logic [3:0] OP_SEG   = 4'd3;
   localparam logic [3:0] OP_LEN   = 4'd4;
   localparam logic [3:0] OP_NUM   = 4'd5;
   localparam logic [3:0] OP_DIV   = 4'd6;
   localparam logic [3:0] OP_INTP  = 4'd7;
   localparam logic [3:0] OP_DIST  = 4'd8;
   localparam logic [3:0] OP_CMP   = 4'd9;
   localparam logic [3:0] OP_ERR   = 4'd10;
   localparam logic [3:0] OP_GAIN  = 4'd11;
   localparam logic [3:0] OP_SMTH  = 4'd12;
   localparam logic [3:0] OP_SMTH2 = 4'd13;

   typedef struct packed {
      logic [3:0] op;
      logic       rd_next;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic t_trivial;
      logic div_done;
   } status_type;

   function automatic logic signed [32:0] sat_sym(input logic signed [32:0] v);
      if (v > SAT_POS) return SAT_POS;
      if (v < SAT_NEG) return SAT_NEG;
      return v;
   endfunction

   // floor(v / 65536)
   function automatic logic signed [47:0] floor16(input logic signed [63:0] v);
      return v[63:16];
   endfunction
endpackage

FILE: hw/rtl/cchc_datapath.sv
// Datapath: point table, segment projection, divider, control law and smoothing
module cchc_datapath #(
   parameter int MAX_POINTS = 64,
   localparam int AW = $clog2(MAX_POINTS)
) (
   input  logic clock,
   input  logic reset,
   input  cchc_pkg::cmd_type cmd,
   output cchc_pkg::status_type status,
   input  logic [AW-1:0] seg_idx,
   input  logic wr_en,
   input  logic [AW-1:0] wr_idx,
   input  logic signed [31:0] wr_x,
   input  logic signed [31:0] wr_y,
   input  logic signed [31:0] wr_z,
   input  logic [30:0] wr_r,
   input  logic signed [31:0] rob_x,
   input  logic signed [31:0] rob_y,
   input  logic signed [31:0] rob_z,
   input  logic step_zero,
   input  logic tbl_empty,
   input  logic [30:0] clearance,
   input  logic [30:0] half_height,
   input  logic [30:0] gain,
   input  logic [30:0] deadband,
   input  logic [30:0] max_speed,
   input  logic [16:0] alpha,
   output logic signed [31:0] smoothed,
   output logic signed [31:0] target
);
   import cchc_pkg::*;

   logic signed [31:0] mem_x [MAX_POINTS];
   logic signed [31:0] mem_y [MAX_POINTS];
   logic signed [31:0] mem_z [MAX_POINTS];
   logic signed [31:0] mem_r [MAX_POINTS];
   logic signed [31:0] rd_x_ff, rd_y_ff, rd_z_ff, rd_r_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_idx] <= wr_x;
         mem_y[wr_idx] <= wr_y;
         mem_z[wr_idx] <= wr_z;
         mem_r[wr_idx] <= {1'b0, wr_r};
      end
      rd_x_ff <= mem_x[seg_idx + AW'(cmd.rd_next)];
      rd_y_ff <= mem_y[seg_idx + AW'(cmd.rd_next)];
      rd_z_ff <= mem_z[seg_idx + AW'(cmd.rd_next)];
      rd_r_ff <= mem_r[seg_idx + AW'(cmd.rd_next)];
   end

   logic signed [31:0] ax_ff, ay_ff, az_ff, ar_ff;
   logic signed [32:0] bax_ff, bay_ff, dz_ff, dr_ff, dx_ff, dy_ff;
   logic [63:0] len_ff, num_ff, d_ff, best_ff, rem_ff;
   logic [16:0] t_ff;
   logic [4:0] dcnt_ff;
   logic have_ff;
   logic signed [47:0] pz_ff, pr_ff, cz_ff, cr_ff, px_ff, py_ff;
   logic signed [47:0] err_ff;
   logic [47:0] mag_ff;
   logic signed [63:0] spd_ff;
   logic signed [31:0] sm_ff, tgt_ff;
   logic signed [63:0] prod_ff;

   logic signed [63:0] sq_a, sq_b;
   logic signed [32:0] ex, ey;
   logic [64:0] rem_sh;
   logic signed [63:0] num_s;
   logic signed [47:0] err_sum;

   always_comb begin
      ex = sat_sym(33'(rob_x) - 33'(px_ff[32:0]));
      ey = sat_sym(33'(rob_y) - 33'(py_ff[32:0]));
      sq_a = dx_ff * dx_ff;
      sq_b = dy_ff * dy_ff;
      rem_sh = {rem_ff, 1'b0};
      num_s = sat_sym(33'(rob_x) - 33'(ax_ff)) * dx_ff;
      err_sum = pz_ff + pr_ff + $signed(48'(half_height)) + $signed(48'(clearance))
         - 48'(rob_z);
   end

   assign status.skip = (len_ff <= SEG_MIN);
   assign status.t_trivial = ($signed(num_ff) <= 0) || (num_ff >= len_ff);
   assign status.div_done = (dcnt_ff == 5'd16);

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_ff <= '0;
         tgt_ff <= '0;
         have_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_INIT: begin
               have_ff <= 1'b0;
            end
            OP_RDA: begin
               ax_ff <= rd_x_ff;
               ay_ff <= rd_y_ff;
               az_ff <= rd_z_ff;
               ar_ff <= rd_r_ff;
               if (seg_idx == '0) begin
                  pz_ff <= 48'(rd_z_ff);
                  pr_ff <= 48'(rd_r_ff);
               end
            end
            OP_SEG: begin
               bax_ff <= 33'(rd_x_ff) - 33'(ax_ff);
               bay_ff <= 33'(rd_y_ff) - 33'(ay_ff);
               dx_ff <= sat_sym(33'(rd_x_ff) - 33'(ax_ff));
               dy_ff <= sat_sym(33'(rd_y_ff) - 33'(ay_ff));
               dz_ff <= 33'(rd_z_ff) - 33'(az_ff);
               dr_ff <= 33'(rd_r_ff) - 33'(ar_ff);
            end
            OP_LEN: begin
               len_ff <= 64'(sq_a) + 64'(sq_b);
               prod_ff <= num_s;
            end
            OP_NUM: begin
               num_ff <= 64'(prod_ff + sat_sym(33'(rob_y) - 33'(ay_ff)) * dy_ff);
               dcnt_ff <= '0;
               t_ff <= '0;
            end
            OP_DIV: begin
               if (dcnt_ff == 5'd0 && t_ff == 17'd0) begin
                  rem_ff <= num_ff;
                  dcnt_ff <= 5'd0;
                  t_ff <= 17'd1 << 16;
               end else begin
                  if (rem_sh >= {1'b0, len_ff}) begin
                     rem_ff <= 64'(rem_sh - {1'b0, len_ff});
                     t_ff <= {t_ff[15:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh[63:0];
                     t_ff <= {t_ff[15:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff + 5'd1;
               end
            end
            OP_INTP: begin
               if (status.t_trivial) begin
                  t_ff <= ($signed(num_ff) <= 0) ? 17'd0 : Q_ONE;
               end
               px_ff <= 48'(ax_ff) + floor16(64'(bax_ff) * 64'($signed({1'b0, (status.t_trivial
                        ? (($signed(num_ff) <= 0) ? 17'd0 : Q_ONE) : t_ff)})));
               py_ff <= 48'(ay_ff) + floor16(64'(bay_ff) * 64'($signed({1'b0, (status.t_trivial
                        ? (($signed(num_ff) <= 0) ? 17'd0 : Q_ONE) : t_ff)})));
            end
            OP_DIST: begin
               d_ff <= 64'(ex) * 64'(ex) + 64'(ey) * 64'(ey);
               cz_ff <= 48'(az_ff) + floor16(64'(dz_ff) * 64'($signed({1'b0, t_ff})));
               cr_ff <= 48'(ar_ff) + floor16(64'(dr_ff) * 64'($signed({1'b0, t_ff})));
            end
            OP_CMP: begin
               if (!have_ff || d_ff < best_ff) begin
                  have_ff <= 1'b1;
                  best_ff <= d_ff;
                  pz_ff <= cz_ff;
                  pr_ff <= cr_ff;
               end
            end
            OP_ERR: begin
               err_ff <= err_sum;
               mag_ff <= (err_sum < 0) ? 48'(-err_sum) : 48'(err_sum);
               prod_ff <= '0;
            end
            OP_GAIN: begin
               prod_ff <= $signed({33'd0, gain}) * $signed({32'd0, mag_ff[47:16]});
               spd_ff <= $signed(64'(({33'd0, gain} * {48'd0, mag_ff[15:0]}) >> 16));
            end
            OP_SMTH: begin
               if (tbl_empty || mag_ff <= 48'(deadband)) begin
                  tgt_ff <= '0;
               end else if (prod_ff + spd_ff > $signed({33'd0, max_speed})) begin
                  tgt_ff <= err_ff < 0 ? -$signed({1'b0, max_speed}) : $signed({1'b0, max_speed});
               end else begin
                  tgt_ff <= err_ff < 0 ? 32'(-(prod_ff + spd_ff)) : 32'(prod_ff + spd_ff);
               end
            end
            OP_SMTH2: begin
               if (step_zero) begin
                  sm_ff <= tgt_ff;
               end else begin
                  sm_ff <= 32'(64'(sm_ff) + 64'(floor16(64'($signed({1'b0,
                     (alpha > Q_ONE ? Q_ONE : alpha)})) * (64'(tgt_ff) - 64'(sm_ff)))));
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign smoothed = sm_ff;
   assign target = tgt_ff;
endmodule

FILE: hw/rtl/cchc_controller.sv
// Controller: sequences the segment walk, division and output stages
module cchc_controller #(
   parameter int MAX_POINTS = 64,
   localparam int AW = $clog2(MAX_POINTS),
   localparam int CW = $clog2(MAX_POINTS + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic req_go,
   input  logic req_tick,
   input  logic [CW-1:0] n_active,
   input  cchc_pkg::status_type status,
   output cchc_pkg::cmd_type cmd,
   output logic [AW-1:0] seg_idx,
   output logic busy,
   output logic done
);
   import cchc_pkg::*;
   `include "cable_clearance_height_controller_macros.svh"

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INIT = 4'd1;
   localparam logic [3:0] S_RDA  = 4'd2;
   localparam logic [3:0] S_RDB  = 4'd3;
   localparam logic [3:0] S_SEG  = 4'd4;
   localparam logic [3:0] S_LEN  = 4'd5;
   localparam logic [3:0] S_NUM  = 4'd6;
   localparam logic [3:0] S_CHK  = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_INTP = 4'd9;
   localparam logic [3:0] S_DIST = 4'd10;
   localparam logic [3:0] S_CMP  = 4'd11;
   localparam logic [3:0] S_ERR  = 4'd12;
   localparam logic [3:0] S_GAIN = 4'd13;
   localparam logic [3:0] S_OUT  = 4'd14;
   localparam logic [3:0] S_SM   = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [4:0] dc_ff, dc_in;
   logic done_ff, done_in;
   logic last_seg;
   logic tick_start;

   assign last_seg = ({1'b0, idx_ff} + 1'b1) >= ({1'b0, n_active} - 1'b1);
   assign tick_start = (state_ff == S_IDLE) && req_go && req_tick;
   assign seg_idx = idx_ff[AW-1:0];
   assign busy = (state_ff != S_IDLE) || done_ff;
   assign done = done_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      dc_in = dc_ff;
      done_in = (state_ff == S_SM);
      cmd = '{op: OP_NONE, rd_next: 1'b0};
      unique case (state_ff)
         S_IDLE: if (tick_start) begin
            state_in = S_INIT;
            idx_in = '0;
         end
         S_INIT: begin
            cmd.op = OP_INIT;
            state_in = S_RDA;
         end
         S_RDA: state_in = S_RDB;
         S_RDB: begin
            cmd.op = OP_RDA;
            cmd.rd_next = 1'b1;
            state_in = (n_active >= CW'(2)) ? S_SEG : S_ERR;
         end
         S_SEG: begin
            cmd.op = OP_SEG;
            state_in = S_LEN;
         end
         S_LEN: begin
            cmd.op = OP_LEN;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.op = OP_NUM;
            dc_in = '0;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (status.skip) begin
               state_in = last_seg ? S_ERR : S_RDA;
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = status.t_trivial ? S_INTP : S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            dc_in = dc_ff + 5'd1;
            if (dc_ff == 5'd16) state_in = S_INTP;
         end
         S_INTP: begin
            cmd.op = OP_INTP;
            state_in = S_DIST;
         end
         S_DIST: begin
            cmd.op = OP_DIST;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.op = OP_CMP;
            idx_in = idx_ff + 1'b1;
            state_in = last_seg ? S_ERR : S_RDA;
         end
         S_ERR: begin
            cmd.op = OP_ERR;
            state_in = S_GAIN;
         end
         S_GAIN: begin
            cmd.op = OP_GAIN;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.op = OP_SMTH;
            state_in = S_SM;
         end
         S_SM: begin
            cmd.op = OP_SMTH2;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         dc_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         dc_ff <= dc_in;
         done_ff <= done_in;
      end
   end

   `CCH_ASSERT_IMPL(a_div_bound, clock, reset, state_ff == S_DIV, dc_ff <= 5'd16, "divider overrun")
   `CCH_ASSERT_NEXT(a_start, clock, reset, tick_start, state_ff == S_INIT, "tick not started")
   `CCH_ASSERT_NEXT(a_done, clock, reset, done, state_ff == S_IDLE, "done not followed by idle")
endmodule

FILE: hw/rtl/cable_clearance_height_controller.sv
// Top level of the cable clearance height controller
// Load transaction: no result, back to back while no tick is busy. Tick transaction:
// rsp_valid rises after a serial walk over the segments (each skipped, clamped or
// divided serially), then error, gain and output stages, with no walk below two points.
// One transaction at a time; the next is taken the cycle after the result is accepted.
// Synchronous active-high reset: control and CSR registers to reset values, smoothed state to zero.
module cable_clearance_height_controller #(
   parameter int MAX_POINTS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_kind,
   input  logic [5:0] req_point_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [30:0] req_point_radius,
   input  logic req_step_is_zero,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_vertical_velocity,
   output logic signed [31:0] rsp_target_velocity,
   output logic rsp_projection_found,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   import cchc_pkg::*;
   `include "cable_clearance_height_controller_macros.svh"

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [6:0] count_ff;
   logic [30:0] clear_ff, half_ff, gain_ff, dead_ff, maxs_ff;
   logic [16:0] alpha_ff;
   logic signed [31:0] rx_ff, ry_ff, rz_ff;
   logic step_ff, empty_ff;
   logic rv_ff;
   logic signed [31:0] ov_ff, ot_ff;
   logic of_ff;
   logic accept, busy, done;
   logic [CW-1:0] n_active;
   cmd_type cmd;
   status_type status;
   logic [AW-1:0] seg_idx;
   logic signed [31:0] sm, tg;

   assign csr_ready = 1'b1;
   assign req_stall = busy || rv_ff;
   assign accept = req_valid && !req_stall;
   assign n_active = (32'(count_ff) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         clear_ff <= 31'd13107;
         half_ff <= 31'd9830;
         gain_ff <= 31'd91750;
         dead_ff <= 31'd983;
         maxs_ff <= 31'd16384;
         alpha_ff <= 17'd145;
         rv_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_POINT_COUNT: count_ff <= csr_data[6:0];
               CSR_CLEARANCE:   clear_ff <= csr_data[30:0];
               CSR_HALF_HEIGHT: half_ff <= csr_data[30:0];
               CSR_GAIN:        gain_ff <= csr_data[30:0];
               CSR_DEADBAND:    dead_ff <= csr_data[30:0];
               CSR_MAX_SPEED:   maxs_ff <= csr_data[30:0];
               CSR_ALPHA:       alpha_ff <= csr_data[16:0];
               default: ;
            endcase
         end
         if (done) rv_ff <= 1'b1;
         else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_kind) begin
         rx_ff <= req_pos_x;
         ry_ff <= req_pos_y;
         rz_ff <= req_pos_z;
         step_ff <= req_step_is_zero;
         empty_ff <= (n_active == '0);
      end
      if (done) begin
         ov_ff <= sm;
         ot_ff <= tg;
         of_ff <= !empty_ff;
      end
   end

   cchc_controller #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock(clock), .reset(reset), .req_go(accept), .req_tick(req_kind),
      .n_active(n_active), .status(status), .cmd(cmd), .seg_idx(seg_idx),
      .busy(busy), .done(done)
   );

   cchc_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .seg_idx(seg_idx),
      .wr_en(accept && !req_kind && (32'(req_point_index) < MAX_POINTS)),
      .wr_idx(AW'(req_point_index)), .wr_x(req_pos_x), .wr_y(req_pos_y), .wr_z(req_pos_z),
      .wr_r(req_point_radius), .rob_x(rx_ff), .rob_y(ry_ff), .rob_z(rz_ff),
      .step_zero(step_ff), .tbl_empty(empty_ff), .clearance(clear_ff),
      .half_height(half_ff), .gain(gain_ff), .deadband(dead_ff), .max_speed(maxs_ff),
      .alpha(alpha_ff), .smoothed(sm), .target(tg)
   );

   assign rsp_valid = rv_ff;
   assign rsp_vertical_velocity = ov_ff;
   assign rsp_target_velocity = ot_ff;
   assign rsp_projection_found = of_ff;

   `CCH_ASSERT_IMPL(a_no_accept_busy, clock, reset, busy, req_stall, "transaction taken while busy")
   `CCH_ASSERT_NEXT(a_rsp_after_done, clock, reset, done, rsp_valid, "result lost")
   `CCH_ASSERT_IMPL(a_no_done_pending, clock, reset, done, !rv_ff, "result overwritten")
endmodule
